[rtl/sitrc_pkg.sv]
// sitrc_pkg: shared widths, character codes, controller states and the
// command and status structs between controller and datapath
// no dependencies
package sitrc_pkg;

  // field and register widths
  localparam int NumW      = 32;
  localparam int CharW     = 8;
  localparam int AlphaW    = 64;
  localparam int LenW      = 5;
  localparam int CfgIdxW   = 2;
  localparam int DigitW    = 4;
  localparam int MaxDigits = 32;
  localparam int CntW      = 6;
  localparam int StepW     = 5;

  // radix limits
  localparam int MaxRadix = 16;
  localparam int MinRadix = 2;

  // character codes
  localparam logic [CharW-1:0] SignMinus = 8'h2D;
  localparam logic [CharW-1:0] SignPlus  = 8'h2B;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgAlphaLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAlphaHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBaseLen   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_DIGIT,
    ST_SIGN,
    ST_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic chk_next;
    logic div_step;
    logic digit_store;
    logic emit_pop;
    logic sel_sign;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic chk_fail;
    logic chk_last;
    logic div_last;
    logic q_zero;
    logic neg;
    logic emit_last;
  } stat_t;

endpackage

[rtl/sitrc_num_if.sv]
// sitrc_num_if: input channel carrying one signed number per beat
// depends on sitrc_pkg
interface sitrc_num_if;
  logic                              valid;
  logic                              ready;
  logic signed [sitrc_pkg::NumW-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

[rtl/sitrc_chr_if.sv]
// sitrc_chr_if: output channel carrying one character and its last flag per beat
// depends on sitrc_pkg
interface sitrc_chr_if;
  logic                        valid;
  logic                        ready;
  logic [sitrc_pkg::CharW-1:0] character;
  logic                        last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

[rtl/sitrc_dp.sv]
// sitrc_dp: configuration registers, alphabet check, serial radix divider,
// digit store and character selection
// depends on sitrc_pkg
module sitrc_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sitrc_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [sitrc_pkg::AlphaW-1:0]         cfg_wdata_i,
  input  logic signed [sitrc_pkg::NumW-1:0]    number_i,
  input  sitrc_pkg::cmd_t                      cmd_i,
  output sitrc_pkg::stat_t                     stat_o,
  output logic [sitrc_pkg::CharW-1:0]          character_o,
  output logic                                 last_o
);

  logic [sitrc_pkg::AlphaW-1:0]   alpha_lo_q, alpha_hi_q;
  logic [sitrc_pkg::LenW-1:0]     base_len_q;
  logic                           neg_q, neg_d;
  logic [sitrc_pkg::NumW-1:0]     quo_q, quo_d, raw;
  logic [sitrc_pkg::DigitW-1:0]   rem_q, rem_d;
  logic [sitrc_pkg::StepW-1:0]    step_q, step_d;
  logic [sitrc_pkg::DigitW-1:0]   chk_idx_q, chk_idx_d;
  logic [sitrc_pkg::CntW-1:0]     nd_q, nd_d, nd_m1;
  logic [sitrc_pkg::DigitW-1:0]   digits_q [sitrc_pkg::MaxDigits];

  logic [2*sitrc_pkg::AlphaW-1:0] alpha;
  logic [sitrc_pkg::CharW-1:0]    sym_chk, sym_out;
  logic [sitrc_pkg::DigitW-1:0]   dig_out;
  logic                           len_bad, dup;
  logic [sitrc_pkg::LenW-1:0]     rem_t;
  logic                           rem_ge;

  assign alpha = {alpha_hi_q, alpha_lo_q};
  assign raw   = number_i;

  // configuration writes, index three is ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_lo_q <= '0;
      alpha_hi_q <= '0;
      base_len_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sitrc_pkg::CfgAlphaLow:  alpha_lo_q <= cfg_wdata_i;
        sitrc_pkg::CfgAlphaHigh: alpha_hi_q <= cfg_wdata_i;
        sitrc_pkg::CfgBaseLen:   base_len_q <= cfg_wdata_i[sitrc_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  // alphabet check, one symbol per cycle against all later symbols in use
  assign sym_chk = alpha[chk_idx_q*sitrc_pkg::CharW +: sitrc_pkg::CharW];
  assign len_bad = (base_len_q < sitrc_pkg::LenW'(sitrc_pkg::MinRadix)) ||
                   (base_len_q > sitrc_pkg::LenW'(sitrc_pkg::MaxRadix));

  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < 16; j++) begin
      if ((sitrc_pkg::LenW'(j) > {1'b0, chk_idx_q}) &&
          (sitrc_pkg::LenW'(j) < base_len_q) &&
          (alpha[j*sitrc_pkg::CharW +: sitrc_pkg::CharW] == sym_chk)) begin
        dup = 1'b1;
      end
    end
  end

  // one restoring division step, remainder stays below the radix
  assign rem_t  = {rem_q, quo_q[sitrc_pkg::NumW-1]};
  assign rem_ge = rem_t >= base_len_q;

  // next values of the working registers
  always_comb begin
    neg_d     = neg_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    step_d    = step_q;
    chk_idx_d = chk_idx_q;
    nd_d      = nd_q;
    if (cmd_i.load) begin
      neg_d     = raw[sitrc_pkg::NumW-1];
      quo_d     = raw[sitrc_pkg::NumW-1] ? (sitrc_pkg::NumW'(0) - raw) : raw;
      rem_d     = '0;
      step_d    = '0;
      chk_idx_d = '0;
      nd_d      = '0;
    end
    if (cmd_i.chk_next) begin
      chk_idx_d = chk_idx_q + 1'b1;
    end
    if (cmd_i.div_step) begin
      quo_d  = {quo_q[sitrc_pkg::NumW-2:0], rem_ge};
      rem_d  = rem_ge ? sitrc_pkg::DigitW'(rem_t - base_len_q)
                      : rem_t[sitrc_pkg::DigitW-1:0];
      step_d = step_q + 1'b1;
    end
    if (cmd_i.digit_store) begin
      rem_d  = '0;
      step_d = '0;
      nd_d   = nd_q + 1'b1;
    end
    if (cmd_i.emit_pop) begin
      nd_d = nd_m1;
    end
  end

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= '0;
      chk_idx_q <= '0;
      nd_q      <= '0;
    end else begin
      step_q    <= step_d;
      chk_idx_q <= chk_idx_d;
      nd_q      <= nd_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (cmd_i.digit_store) begin
      digits_q[nd_q[sitrc_pkg::StepW-1:0]] <= rem_q;
    end
  end

  // character selection, digits come out most significant first
  assign nd_m1   = nd_q - 1'b1;
  assign dig_out = digits_q[nd_m1[sitrc_pkg::StepW-1:0]];
  assign sym_out = alpha[dig_out*sitrc_pkg::CharW +: sitrc_pkg::CharW];

  assign character_o = cmd_i.sel_sign ? sitrc_pkg::SignMinus : sym_out;
  assign last_o      = !cmd_i.sel_sign && stat_o.emit_last;

  // status
  assign stat_o.chk_fail  = len_bad || dup || (sym_chk == sitrc_pkg::SignMinus) ||
                            (sym_chk == sitrc_pkg::SignPlus);
  assign stat_o.chk_last  = {1'b0, chk_idx_q} == (base_len_q - 1'b1);
  assign stat_o.div_last  = step_q == {sitrc_pkg::StepW{1'b1}};
  assign stat_o.q_zero    = quo_q == '0;
  assign stat_o.neg       = neg_q;
  assign stat_o.emit_last = nd_q == sitrc_pkg::CntW'(1);

endmodule

[rtl/sitrc_ctrl.sv]
// sitrc_ctrl: state machine that sequences check, division, digit store
// and character beats; drives the channel handshakes
// depends on sitrc_pkg
module sitrc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  sitrc_pkg::stat_t stat_i,
  output sitrc_pkg::cmd_t  cmd_o
);

  sitrc_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sitrc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sitrc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = sitrc_pkg::ST_CHECK;
      end
      sitrc_pkg::ST_CHECK: begin
        priority if (stat_i.chk_fail) state_d = sitrc_pkg::ST_IDLE;
        else if (stat_i.chk_last) state_d = sitrc_pkg::ST_DIVIDE;
        else state_d = sitrc_pkg::ST_CHECK;
      end
      sitrc_pkg::ST_DIVIDE: begin
        if (stat_i.div_last) state_d = sitrc_pkg::ST_DIGIT;
      end
      sitrc_pkg::ST_DIGIT: begin
        priority if (!stat_i.q_zero) state_d = sitrc_pkg::ST_DIVIDE;
        else if (stat_i.neg) state_d = sitrc_pkg::ST_SIGN;
        else state_d = sitrc_pkg::ST_EMIT;
      end
      sitrc_pkg::ST_SIGN: begin
        if (out_ready_i) state_d = sitrc_pkg::ST_EMIT;
      end
      sitrc_pkg::ST_EMIT: begin
        if (out_ready_i && stat_i.emit_last) state_d = sitrc_pkg::ST_IDLE;
      end
      default: state_d = sitrc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      sitrc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      sitrc_pkg::ST_CHECK:  cmd_o.chk_next = 1'b1;
      sitrc_pkg::ST_DIVIDE: cmd_o.div_step = 1'b1;
      sitrc_pkg::ST_DIGIT:  cmd_o.digit_store = 1'b1;
      sitrc_pkg::ST_SIGN: begin
        out_valid_o    = 1'b1;
        cmd_o.sel_sign = 1'b1;
      end
      sitrc_pkg::ST_EMIT: begin
        out_valid_o    = 1'b1;
        cmd_o.emit_pop = out_ready_i;
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input ready while a character beat is offered");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sitrc_pkg::ST_EMIT && out_ready_i && stat_i.emit_last) |=> in_ready_o)
    else $error("not ready for a new number after the last character");

  a_div_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sitrc_pkg::ST_DIVIDE && !stat_i.div_last) |=>
      state_q == sitrc_pkg::ST_DIVIDE)
    else $error("division left before its last step");

  a_bad_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sitrc_pkg::ST_CHECK && stat_i.chk_fail) |=> in_ready_o && !out_valid_o)
    else $error("invalid alphabet did not drop the number");
`endif

endmodule

[rtl/signed_integer_to_radix_chars.sv]
// signed_integer_to_radix_chars: top level, signed number to radix characters
// depends on sitrc_pkg, sitrc_num_if, sitrc_chr_if, sitrc_ctrl, sitrc_dp
//
//   channel   dir   payload                 per number
//   num_i     in    number[31:0] signed     one beat
//   chr_o     out   character[7:0], last    0 to 33 beats
//   cfg_*     in    idx[1:0], wdata[63:0]   write only, no stall
//
// per number: the symbol check over the radix, one symbol a cycle, then for each
// digit 32 serial division steps plus a store, then the character beats, each
// held while the output stalls
// an invalid alphabet ends the number after the check with no beats
// reset clears state and configuration to zero; output stalls hold the beat
// one number at a time: num_i is not ready until the last beat is taken
module signed_integer_to_radix_chars (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sitrc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sitrc_pkg::AlphaW-1:0]  cfg_wdata_i,
  sitrc_num_if.sink                     num_i,
  sitrc_chr_if.source                   chr_o
);

  sitrc_pkg::cmd_t  cmd;
  sitrc_pkg::stat_t stat;

  // sequencing and handshakes
  sitrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (num_i.valid),
    .in_ready_o  (num_i.ready),
    .out_valid_o (chr_o.valid),
    .out_ready_i (chr_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // registers, divider and character selection
  sitrc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .number_i    (num_i.number),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .character_o (chr_o.character),
    .last_o      (chr_o.last)
  );

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// testbench: self-checking regression for signed_integer_to_radix_chars
// depends on sitrc_pkg, sitrc_num_if, sitrc_chr_if and the block itself
module testbench;
  import sitrc_pkg::*;

  // index with no register behind it, writes to it must be dropped
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  localparam int HoldCycles  = 400;
  localparam int CheckCycles = 64;    // symbol check of up to 16 symbols
  localparam int EndCycles   = 1200;  // one full radix 2 conversion
  localparam int RandomItems = 170;
  localparam int LimitNs     = 20_000_000;

  typedef struct packed {
    logic [CharW-1:0] character;
    logic             last;
  } char_beat_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [AlphaW-1:0]  cfg_wdata_i;

  sitrc_num_if num_if ();
  sitrc_chr_if chr_if ();

  signed_integer_to_radix_chars dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .num_i       (num_if),
    .chr_o       (chr_if)
  );

  // shadow copy of the configuration registers
  logic [AlphaW-1:0] cfg_alpha_lo = '0;
  logic [AlphaW-1:0] cfg_alpha_hi = '0;
  logic [LenW-1:0]   cfg_base_len = '0;

  char_beat_t expected_chars[$];
  char_beat_t head_beat;
  int         mismatch_count = 0;
  bit         idle_on = 1'b1;
  logic       hold_active = 1'b0;
  int         stall_left = 0;
  event       hold_off_start;

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // symbol lookup in the shadow alphabet
  function automatic logic [CharW-1:0] symbol_of(input logic [DigitW-1:0] idx);
    logic [AlphaW-1:0] word;
    word = idx[3] ? cfg_alpha_hi : cfg_alpha_lo;
    return word[idx[2:0]*8 +: 8];
  endfunction

  // radix in range, no sign symbol and no repeated symbol among those in use
  function automatic bit alphabet_valid();
    int unsigned len;
    logic [CharW-1:0] s;
    len = cfg_base_len;
    if (len < MinRadix || len > MaxRadix) return 1'b0;
    for (int i = 0; i < len; i++) begin
      s = symbol_of(DigitW'(i));
      if (s == SignMinus || s == SignPlus) return 1'b0;
      for (int j = i + 1; j < len; j++) begin
        if (symbol_of(DigitW'(j)) == s) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // queue the characters that one number turns into
  function automatic void predict_chars(input logic [NumW-1:0] raw);
    logic [NumW-1:0]   mag;
    logic [NumW-1:0]   radix;
    logic [DigitW-1:0] digit_q[$];
    logic [DigitW-1:0] d;
    char_beat_t        beat;
    if (!alphabet_valid()) return;
    radix = NumW'(cfg_base_len);
    mag = raw[NumW-1] ? (~raw + 1'b1) : raw;
    do begin
      digit_q.push_front(DigitW'(mag % radix));
      mag = mag / radix;
    end while (mag != 0);
    if (raw[NumW-1]) begin
      beat.character = SignMinus;
      beat.last      = 1'b0;
      expected_chars.push_back(beat);
    end
    while (digit_q.size() != 0) begin
      d = digit_q.pop_front();
      beat.character = symbol_of(d);
      beat.last      = (digit_q.size() == 0);
      expected_chars.push_back(beat);
    end
  endfunction

  // one register write; the caller lowers the write enable after a batch
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [AlphaW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CfgAlphaLow:  cfg_alpha_lo = data;
      CfgAlphaHigh: cfg_alpha_hi = data;
      CfgBaseLen:   cfg_base_len = data[LenW-1:0];
      default: ;
    endcase
  endtask

  task automatic load_alphabet(input string syms, input logic [LenW-1:0] len,
                               input logic [CharW-1:0] filler,
                               input logic [AlphaW-LenW-1:0] len_upper);
    logic [AlphaW-1:0] lo;
    logic [AlphaW-1:0] hi;
    logic [CharW-1:0]  b;
    for (int i = 0; i < 16; i++) begin
      b = (i < syms.len()) ? syms[i] : filler;
      if (i < 8) lo[i*8 +: 8] = b;
      else hi[(i-8)*8 +: 8] = b;
    end
    write_reg(CfgAlphaLow, lo);
    write_reg(CfgAlphaHigh, hi);
    write_reg(CfgBaseLen, {len_upper, len});
    cfg_we_i <= 1'b0;
  endtask

  // random alphabet, mostly valid, sometimes broken in one of several ways
  task automatic randomize_alphabet();
    logic [CharW-1:0]  syms[16];
    bit                used[256];
    logic [AlphaW-1:0] lo;
    logic [AlphaW-1:0] hi;
    logic [AlphaW-1:0] len_word;
    int unsigned       len;
    int unsigned       mode;
    int unsigned       i;
    int unsigned       j;
    for (int k = 0; k < 16; k++) syms[k] = CharW'($urandom_range(0, 255));
    used[SignMinus] = 1'b1;
    used[SignPlus]  = 1'b1;
    mode = $urandom_range(0, 19);
    len = ($urandom_range(0, 9) == 0) ? 2 : $urandom_range(3, 16);
    if (mode == 0) len = $urandom_range(0, 1);
    if (mode == 1) len = $urandom_range(17, 31);
    for (int k = 0; k < 16 && k < len; k++) begin
      do syms[k] = CharW'($urandom_range(0, 255)); while (used[syms[k]]);
      used[syms[k]] = 1'b1;
    end
    if (mode == 2) begin
      syms[$urandom_range(0, len - 1)] = $urandom_range(0, 1) ? SignMinus : SignPlus;
    end else if (mode == 3) begin
      i = $urandom_range(0, len - 2);
      j = $urandom_range(i + 1, len - 1);
      syms[j] = syms[i];
    end
    for (int k = 0; k < 8; k++) begin
      lo[k*8 +: 8] = syms[k];
      hi[k*8 +: 8] = syms[k+8];
    end
    len_word = {$urandom(), $urandom()};
    len_word[LenW-1:0] = LenW'(len);
    write_reg(CfgAlphaLow, lo);
    if ($urandom_range(0, 3) == 0) write_reg(CfgUnused, {$urandom(), $urandom()});
    write_reg(CfgAlphaHigh, hi);
    write_reg(CfgBaseLen, len_word);
    cfg_we_i <= 1'b0;
  endtask

  // mix of small values, extremes, radix power edges and full range
  function automatic logic [NumW-1:0] random_number();
    logic [NumW-1:0] v;
    logic [NumW-1:0] p;
    logic [NumW-1:0] r;
    case ($urandom_range(0, 7))
      0: v = $urandom_range(0, 40) - 20;
      1: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = '0;
          3: v = '1;
          default: v = 32'd1;
        endcase
      end
      2: begin
        r = (cfg_base_len >= MinRadix) ? NumW'(cfg_base_len) : 32'd10;
        p = 32'd1;
        repeat ($urandom_range(1, 31)) if (p <= 32'hFFFF_FFFF / r) p = p * r;
        v = p - $urandom_range(0, 1);
        if ($urandom_range(0, 1)) v = ~v + 1'b1;
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // offer one number, hold it until taken, then queue its characters
  task automatic send_number(input logic [NumW-1:0] n);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      num_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    num_if.valid  <= 1'b1;
    num_if.number <= n;
    do @(posedge clk_i); while (!num_if.ready);
    predict_chars(n);
  endtask

  // drop valid and let every queued character come back
  task automatic wait_quiet();
    num_if.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (CheckCycles) @(posedge clk_i);
  endtask

  // receiver: random stall bursts, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_active) begin
      chr_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      chr_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      chr_if.ready <= 1'b0;
      stall_left   <= $urandom_range(1, 14) - 1;
    end else begin
      chr_if.ready <= 1'b1;
    end
  end

  // long hold-off counter
  always begin
    @(hold_off_start);
    hold_active <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_active <= 1'b0;
  end

  // compare each output beat with the oldest expected character
  always @(posedge clk_i) begin
    if (rst_ni && chr_if.valid && chr_if.ready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected beat: character %02h last %b", chr_if.character, chr_if.last);
        mismatch_count++;
      end else begin
        head_beat = expected_chars.pop_front();
        if (chr_if.character !== head_beat.character) begin
          $error("character mismatch: expected %02h, actual %02h",
                 head_beat.character, chr_if.character);
          mismatch_count++;
        end
        if (chr_if.last !== head_beat.last) begin
          $error("last mismatch: expected %b, actual %b", head_beat.last, chr_if.last);
          mismatch_count++;
        end
      end
    end
  end

  // reset configuration has radix zero, so nothing comes out
  task automatic test_reset_alphabet();
    send_number(32'd0);
    send_number(32'hFFFF_FFFF);
    wait_quiet();
  endtask

  // radix too small, too large, sign symbols and repeats in use
  task automatic test_invalid_alphabets();
    load_alphabet("0123456789", 5'd1, "x", '0);
    send_number(32'd5);
    wait_quiet();
    load_alphabet("0123456789ABCDEF", 5'd17, "G", '0);
    send_number(32'd5);
    wait_quiet();
    load_alphabet("0123456789ABCDEF", 5'd31, "G", '0);
    send_number(32'h8000_0000);
    wait_quiet();
    load_alphabet("01-3", 5'd4, "x", '0);
    send_number(32'd7);
    wait_quiet();
    load_alphabet("+123", 5'd4, "x", '0);
    send_number(32'hFFFF_FFF9);
    wait_quiet();
    load_alphabet("0120", 5'd4, "x", '0);
    send_number(32'd9);
    wait_quiet();
  endtask

  // extremes of the input in decimal, binary and a radix with a zero byte symbol
  task automatic test_extreme_numbers();
    // upper bits of the length word must be dropped
    load_alphabet("0123456789", 5'd10, "x", '1);
    send_number(32'd0);
    send_number(32'd1);
    send_number(32'hFFFF_FFFF);
    send_number(32'h7FFF_FFFF);
    send_number(32'h8000_0000);
    send_number(32'd10);
    send_number(32'hFFFF_FFF6);
    wait_quiet();
    // sign bytes and repeats beyond the radix are ignored
    load_alphabet("01", 5'd2, SignMinus, '0);
    send_number(32'h8000_0000);
    send_number(32'h7FFF_FFFF);
    send_number(32'd0);
    wait_quiet();
    // symbol 15 is a zero byte
    load_alphabet("0123456789ABCDE", 5'd16, 8'h00, '0);
    send_number(32'd15);
    send_number(32'hFFFF_FF0F);
    wait_quiet();
  endtask

  // a write to the unused index leaves the alphabet alone
  task automatic test_unmapped_register();
    write_reg(CfgUnused, {8{SignMinus}});
    cfg_we_i <= 1'b0;
    send_number(32'd42);
    send_number(32'h8000_0000);
    wait_quiet();
  endtask

  // receiver holds off while numbers keep coming, input must stall
  task automatic test_output_hold();
    load_alphabet("0123456789", 5'd10, "x", '0);
    -> hold_off_start;
    repeat (6) send_number(random_number());
    wait_quiet();
  endtask

  // random alphabets, each followed by a batch of random numbers
  task automatic test_random_numbers();
    int productive;
    int count;
    productive = 0;
    while (productive < RandomItems) begin
      randomize_alphabet();
      count = alphabet_valid() ? $urandom_range(4, 14) : $urandom_range(1, 3);
      repeat (count) send_number(random_number());
      if (alphabet_valid()) productive += count;
      wait_quiet();
    end
  endtask

  // no idling on either side
  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (3) begin
      do randomize_alphabet(); while (!alphabet_valid());
      repeat (8) send_number(random_number());
      wait_quiet();
    end
  endtask

  // run limit
  initial begin
    #(LimitNs);
    $display("signed_integer_to_radix_chars regression: fail");
    $finish;
  end

  // test sequence
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgAlphaLow;
    cfg_wdata_i   = '0;
    num_if.valid  = 1'b0;
    num_if.number = '0;
    chr_if.ready  = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_alphabet();
    test_invalid_alphabets();
    test_extreme_numbers();
    test_unmapped_register();
    test_output_hold();
    test_random_numbers();
    test_back_to_back();

    wait_quiet();
    repeat (EndCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("signed_integer_to_radix_chars regression: pass");
    end else begin
      $display("signed_integer_to_radix_chars regression: fail");
    end
    $finish;
  end

endmodule
